[design/scb_pkg.sv]
// ----------------------------------------------------------------------------
// scb_pkg
// Shared constants for the Shannon code table builder: operation codes,
// field widths and parameter defaults.
// ----------------------------------------------------------------------------
package scb_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_BUILD = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Field widths
    localparam int SYM_W  = 8;
    localparam int OCC_W  = 16;
    localparam int RANK_W = 8;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 24;

    // Longest codeword
    localparam int LEN_MAX = 24;

    // Parameter defaults
    localparam int DEF_MAX_SYMBOLS = 256;
    localparam int DEF_COUNT_BITS  = 16;

endpackage

[design/shannon_code_builder.sv]
// ----------------------------------------------------------------------------
// shannon_code_builder
// Collects (symbol, count) pairs in a table memory and builds a Shannon code.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tuser carries the op (clear, load, build, read),
//   s_axis_tdata carries symbol, occurrences and rank. Only a read produces
//   an item on the output stream: symbol, code length and codeword in
//   m_axis_tdata, rank_valid in m_axis_tuser.
//   Clear and load are taken one per cycle while no build runs and no read
//   is pending. A read result passes through the table memory read
//   register, then the output register; the input is held while the read
//   is pending, so a new item is not taken until the result has moved on.
//   Build runs a sequencer over the symbol/count memory: an insertion sort
//   of the N stored entries, then a code pass that gives each entry its
//   code length (at most 24) and codeword. Input is not taken during build.
//   Reset clears the entry count, total and built flag; the table memories
//   are not cleared and need no clearing pass.
//   When the output is stalled, loads, clears and builds are still taken; a
//   read waits in a pending slot and holds the input until the output
//   register frees.
// ----------------------------------------------------------------------------
module shannon_code_builder #(
    parameter int MAX_SYMBOLS = scb_pkg::DEF_MAX_SYMBOLS,
    parameter int COUNT_BITS  = scb_pkg::DEF_COUNT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // symbol[7:0], occurrences[23:8], rank[31:24]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_symbol[7:0], code_length[12:8],
                                        // code_bits[36:13], zero fill[39:37]
    output logic [0:0]  m_axis_tuser    // rank_valid[0]
);

    localparam int IW  = $clog2(MAX_SYMBOLS);
    localparam int CW  = $clog2(MAX_SYMBOLS + 1);
    localparam int TW  = COUNT_BITS + 8;
    localparam int AW  = scb_pkg::SYM_W + COUNT_BITS;
    localparam int BW  = scb_pkg::LEN_W + scb_pkg::CODE_W;
    localparam int CMPW = (CW > scb_pkg::RANK_W) ? CW : scb_pkg::RANK_W + 1;

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_S_NEXT = 4'd1;
    localparam logic [3:0] ST_S_KEY  = 4'd2;
    localparam logic [3:0] ST_S_CMP  = 4'd3;
    localparam logic [3:0] ST_S_PUT  = 4'd4;
    localparam logic [3:0] ST_C_NEXT = 4'd5;
    localparam logic [3:0] ST_C_LOAD = 4'd6;
    localparam logic [3:0] ST_C_STEP = 4'd7;

    // Input fields
    logic [1:0]                 op;
    logic [scb_pkg::SYM_W-1:0]  in_sym;
    logic [scb_pkg::OCC_W-1:0]  in_occ;
    logic [scb_pkg::RANK_W-1:0] in_rank;
    logic [23:0]                occ_ext;
    logic [COUNT_BITS-1:0]      in_cnt;
    logic                       accept;

    assign op      = s_axis_tuser;
    assign in_sym  = s_axis_tdata[7:0];
    assign in_occ  = s_axis_tdata[23:8];
    assign in_rank = s_axis_tdata[31:24];
    assign occ_ext = {8'b0, in_occ};
    assign in_cnt  = occ_ext[COUNT_BITS-1:0];

    // Table memories: A holds {symbol, count}, B holds {length, code}
    logic [AW-1:0] mem_a [MAX_SYMBOLS];
    logic [BW-1:0] mem_b [MAX_SYMBOLS];
    logic [AW-1:0] a_rdata_reg;
    logic [BW-1:0] b_rdata_reg;
    logic          a_we, a_re, b_we, b_re;
    logic [IW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    logic [AW-1:0] a_wdata;
    logic [BW-1:0] b_wdata;

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[a_waddr] <= a_wdata;
        end
        if (a_re)
        begin
            a_rdata_reg <= mem_a[a_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[b_waddr] <= b_wdata;
        end
        if (b_re)
        begin
            b_rdata_reg <= mem_b[b_raddr];
        end
    end

    // Control and work registers
    logic [3:0]                 state_reg, state_next;
    logic [CW-1:0]              used_reg, used_next;
    logic [TW-1:0]              total_reg, total_next;
    logic                       built_reg, built_next;
    logic [CW-1:0]              i_reg, i_next;
    logic [CW-1:0]              j_reg, j_next;
    logic [AW-1:0]              key_reg, key_next;
    logic [COUNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [TW:0]                sh_reg, sh_next;
    logic [TW:0]                rem_reg, rem_next;
    logic [TW-1:0]              cum_reg, cum_next;
    logic [scb_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [scb_pkg::CODE_W-1:0] code_reg, code_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic                       pend_ok_reg, pend_ok_next;
    logic                       m_valid_reg, m_valid_next;
    logic [scb_pkg::SYM_W-1:0]  m_sym_reg, m_sym_next;
    logic [scb_pkg::LEN_W-1:0]  m_len_reg, m_len_next;
    logic [scb_pkg::CODE_W-1:0] m_code_reg, m_code_next;
    logic                       m_rv_reg, m_rv_next;

    // Step helpers
    logic [CW-1:0] i_inc, i_dec, j_dec;
    logic [TW:0]   rem2, total_x;
    logic          code_bit;

    assign i_inc    = i_reg + 1'b1;
    assign i_dec    = i_reg - 1'b1;
    assign j_dec    = j_reg - 1'b1;
    assign total_x  = {1'b0, total_reg};
    assign rem2     = {rem_reg[TW-1:0], 1'b0};
    assign code_bit = (rem2 >= total_x);

    assign s_axis_tready = (state_reg == ST_IDLE) && !rd_pend_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        total_next   = total_reg;
        built_next   = built_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        key_next     = key_reg;
        cnt_next     = cnt_reg;
        sh_next      = sh_reg;
        rem_next     = rem_reg;
        cum_next     = cum_reg;
        len_next     = len_reg;
        code_next    = code_reg;
        rd_pend_next = rd_pend_reg;
        pend_ok_next = pend_ok_reg;
        m_valid_next = m_valid_reg;
        m_sym_next   = m_sym_reg;
        m_len_next   = m_len_reg;
        m_code_next  = m_code_reg;
        m_rv_next    = m_rv_reg;
        a_we    = 1'b0;
        a_re    = 1'b0;
        b_we    = 1'b0;
        b_re    = 1'b0;
        a_waddr = used_reg[IW-1:0];
        a_wdata = {in_sym, in_cnt};
        a_raddr = in_rank[IW-1:0];
        b_waddr = i_reg[IW-1:0];
        b_wdata = {len_reg, code_reg};
        b_raddr = in_rank[IW-1:0];

        // Output register: drain, then fill from a pending read
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (rd_pend_reg && (!m_valid_reg || m_axis_tready))
        begin
            rd_pend_next = 1'b0;
            m_valid_next = 1'b1;
            m_rv_next    = pend_ok_reg;
            m_sym_next   = pend_ok_reg ? a_rdata_reg[AW-1:COUNT_BITS] : '0;
            m_len_next   = pend_ok_reg ? b_rdata_reg[BW-1:scb_pkg::CODE_W] : '0;
            m_code_next  = pend_ok_reg ? b_rdata_reg[scb_pkg::CODE_W-1:0] : '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        scb_pkg::OP_CLEAR:
                        begin
                            used_next  = '0;
                            total_next = '0;
                            built_next = 1'b0;
                        end
                        scb_pkg::OP_LOAD:
                        begin
                            if ((in_cnt != '0) && (used_reg < CW'(MAX_SYMBOLS)))
                            begin
                                a_we       = 1'b1;
                                used_next  = used_reg + 1'b1;
                                total_next = total_reg + TW'(in_cnt);
                                built_next = 1'b0;
                            end
                        end
                        scb_pkg::OP_BUILD:
                        begin
                            i_next     = CW'(1);
                            state_next = ST_S_NEXT;
                        end
                        default:
                        begin
                            // read: fetch both memories, result next cycle
                            a_re         = 1'b1;
                            b_re         = 1'b1;
                            rd_pend_next = 1'b1;
                            pend_ok_next = built_reg &&
                                           (CMPW'(in_rank) < CMPW'(used_reg));
                        end
                    endcase
                end
            end

            // Insertion sort, descending counts, stable
            ST_S_NEXT:
            begin
                if (i_reg >= used_reg)
                begin
                    i_next     = '0;
                    cum_next   = '0;
                    state_next = ST_C_NEXT;
                end
                else
                begin
                    a_re       = 1'b1;
                    a_raddr    = i_reg[IW-1:0];
                    state_next = ST_S_KEY;
                end
            end
            ST_S_KEY:
            begin
                key_next   = a_rdata_reg;
                j_next     = i_reg;
                a_re       = 1'b1;
                a_raddr    = i_dec[IW-1:0];
                state_next = ST_S_CMP;
            end
            ST_S_CMP:
            begin
                if (a_rdata_reg[COUNT_BITS-1:0] < key_reg[COUNT_BITS-1:0])
                begin
                    // shift the smaller entry up one place
                    a_we    = 1'b1;
                    a_waddr = j_reg[IW-1:0];
                    a_wdata = a_rdata_reg;
                    j_next  = j_dec;
                    if (j_dec == '0)
                    begin
                        state_next = ST_S_PUT;
                    end
                    else
                    begin
                        a_re    = 1'b1;
                        a_raddr = IW'(j_dec - 1'b1);
                    end
                end
                else
                begin
                    state_next = ST_S_PUT;
                end
            end
            ST_S_PUT:
            begin
                a_we       = 1'b1;
                a_waddr    = j_reg[IW-1:0];
                a_wdata    = key_reg;
                i_next     = i_inc;
                state_next = ST_S_NEXT;
            end

            // Code pass: length and codeword bits one step a cycle
            ST_C_NEXT:
            begin
                if (i_reg >= used_reg)
                begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    a_re       = 1'b1;
                    a_raddr    = i_reg[IW-1:0];
                    state_next = ST_C_LOAD;
                end
            end
            ST_C_LOAD:
            begin
                cnt_next   = a_rdata_reg[COUNT_BITS-1:0];
                sh_next    = (TW+1)'(a_rdata_reg[COUNT_BITS-1:0]);
                rem_next   = {1'b0, cum_reg};
                len_next   = '0;
                code_next  = '0;
                state_next = ST_C_STEP;
            end
            ST_C_STEP:
            begin
                if ((len_reg < scb_pkg::LEN_W'(scb_pkg::LEN_MAX)) && (sh_reg < total_x))
                begin
                    len_next  = len_reg + 1'b1;
                    sh_next   = {sh_reg[TW-1:0], 1'b0};
                    rem_next  = code_bit ? (rem2 - total_x) : rem2;
                    code_next = {code_reg[scb_pkg::CODE_W-2:0], code_bit};
                end
                else
                begin
                    b_we       = 1'b1;
                    cum_next   = cum_reg + TW'(cnt_reg);
                    i_next     = i_inc;
                    state_next = ST_C_NEXT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            total_reg   <= '0;
            built_reg   <= 1'b0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            total_reg   <= total_next;
            built_reg   <= built_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Work and payload registers
    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        key_reg     <= key_next;
        cnt_reg     <= cnt_next;
        sh_reg      <= sh_next;
        rem_reg     <= rem_next;
        cum_reg     <= cum_next;
        len_reg     <= len_next;
        code_reg    <= code_next;
        pend_ok_reg <= pend_ok_next;
        m_sym_reg   <= m_sym_next;
        m_len_reg   <= m_len_next;
        m_code_reg  <= m_code_next;
        m_rv_reg    <= m_rv_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_code_reg, m_len_reg, m_sym_reg};
    assign m_axis_tuser  = m_rv_reg;

endmodule

[design/scb_checker.sv]
// ----------------------------------------------------------------------------
// scb_checker
// Port-level checks for the Shannon code table builder, bound to the top.
// ----------------------------------------------------------------------------
module scb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Invalid read reports all zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 40'd0)
        else $error("invalid read carries data");

    // Length never above the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[12:8] <= 5'd24)
        else $error("code length above 24");

    // Codeword fits its length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[36:13] >> m_axis_tdata[12:8]) == 24'd0)
        else $error("codeword wider than its length");

endmodule

bind shannon_code_builder scb_checker u_scb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[bench/tb_shannon_code_builder.sv]
// ----------------------------------------------------------------------------
// tb_shannon_code_builder
// Self-checking bench for the Shannon code table builder. Tables are loaded
// and built, then ranks are read back and compared against a local model of
// the sort and the code assignment. Sender bursts and receiver stalls random.
// ----------------------------------------------------------------------------
module tb_shannon_code_builder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = scb_pkg::DEF_MAX_SYMBOLS;
    localparam int STALL_LIMIT = 400000;

    typedef struct packed {
        logic [scb_pkg::SYM_W-1:0]  sym;
        logic [scb_pkg::LEN_W-1:0]  len;
        logic [scb_pkg::CODE_W-1:0] code;
        logic                       valid;
    } code_entry_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // symbol[7:0], occurrences[23:8], rank[31:24]
    logic [1:0]  s_axis_tuser;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // out_symbol[7:0], code_length[12:8], code_bits[36:13]
    logic [0:0]  m_axis_tuser;   // rank_valid[0]

    shannon_code_builder dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Local table copy
    logic [scb_pkg::SYM_W-1:0]  tbl_sym  [TABLE_DEPTH];
    logic [scb_pkg::OCC_W-1:0]  tbl_cnt  [TABLE_DEPTH];
    logic [scb_pkg::LEN_W-1:0]  tbl_len  [TABLE_DEPTH];
    logic [scb_pkg::CODE_W-1:0] tbl_code [TABLE_DEPTH];
    int unsigned                tbl_used;
    logic [31:0]                tbl_total;
    bit                         tbl_built;

    code_entry_t pending_reads[$];
    int          errors;
    int          reads_seen;
    int          items_sent;
    int          idle_cycles;
    int          burst_left;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Sort, then assign lengths and codes by exact remainder doubling
    task automatic build_table();
        logic [scb_pkg::SYM_W-1:0]  s;
        logic [scb_pkg::OCC_W-1:0]  c;
        logic [63:0]                cum;
        logic [63:0]                rem;
        int                         j;
        int unsigned                len;
        logic [scb_pkg::CODE_W-1:0] code;
        cum = 0;
        for (int i = 1; i < tbl_used; i++)
        begin
            s = tbl_sym[i];
            c = tbl_cnt[i];
            j = i;
            while (j > 0 && tbl_cnt[j-1] < c)
            begin
                tbl_sym[j] = tbl_sym[j-1];
                tbl_cnt[j] = tbl_cnt[j-1];
                j--;
            end
            tbl_sym[j] = s;
            tbl_cnt[j] = c;
        end
        for (int i = 0; i < tbl_used; i++)
        begin
            len = 0;
            code = '0;
            rem = cum;
            while (len < scb_pkg::LEN_MAX &&
                   ((64'(tbl_cnt[i])) << len) < 64'(tbl_total))
                len++;
            for (int b = 0; b < len; b++)
            begin
                rem = rem << 1;
                code = code << 1;
                if (rem >= 64'(tbl_total))
                begin
                    rem = rem - 64'(tbl_total);
                    code[0] = 1'b1;
                end
            end
            tbl_len[i] = scb_pkg::LEN_W'(len);
            tbl_code[i] = code;
            cum = cum + tbl_cnt[i];
        end
        tbl_built = 1'b1;
    endtask

    // Apply one accepted item to the local copy
    task automatic track_item(input logic [1:0] op, input logic [scb_pkg::SYM_W-1:0] sym,
                              input logic [scb_pkg::OCC_W-1:0] occ,
                              input logic [scb_pkg::RANK_W-1:0] rank);
        code_entry_t e;
        case (op)
            scb_pkg::OP_CLEAR:
            begin
                tbl_used = 0;
                tbl_total = 0;
                tbl_built = 1'b0;
            end
            scb_pkg::OP_LOAD:
            begin
                if (occ != 0 && tbl_used < TABLE_DEPTH)
                begin
                    tbl_sym[tbl_used] = sym;
                    tbl_cnt[tbl_used] = occ;
                    tbl_used++;
                    tbl_total = tbl_total + occ;
                    tbl_built = 1'b0;
                end
            end
            scb_pkg::OP_BUILD: build_table();
            default:
            begin
                e = '0;
                if (tbl_built && rank < tbl_used)
                begin
                    e.sym = tbl_sym[rank];
                    e.len = tbl_len[rank];
                    e.code = tbl_code[rank];
                    e.valid = 1'b1;
                end
                pending_reads.push_back(e);
            end
        endcase
    endtask

    // Send one item, honoring bursts and gaps
    task automatic send_item(input logic [1:0] op, input logic [scb_pkg::SYM_W-1:0] sym,
                             input logic [scb_pkg::OCC_W-1:0] occ,
                             input logic [scb_pkg::RANK_W-1:0] rank);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {rank, occ, sym};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_item(op, sym, occ, rank);
        items_sent++;
    endtask

    task automatic drain_reads();
        s_axis_tvalid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic read_all(input int extra);
        for (int r = 0; r < tbl_used + extra; r++)
            send_item(scb_pkg::OP_READ, 8'($urandom), 16'($urandom),
                      scb_pkg::RANK_W'(r));
    endtask

    // Extremes and every special case
    task automatic test_directed();
        send_item(scb_pkg::OP_READ, 8'hFF, 16'hFFFF, 8'd0);    // read before any build
        send_item(scb_pkg::OP_BUILD, 8'h00, 16'h0000, 8'h00);  // build on empty table
        send_item(scb_pkg::OP_READ, 8'h00, 16'h0000, 8'd0);
        send_item(scb_pkg::OP_LOAD, 8'hA5, 16'h0000, 8'h00);   // zero count ignored
        send_item(scb_pkg::OP_LOAD, 8'h00, 16'hFFFF, 8'hFF);
        send_item(scb_pkg::OP_BUILD, 8'h00, 16'h0000, 8'h00);  // single entry: length 0
        send_item(scb_pkg::OP_READ, 8'h00, 16'h0000, 8'd0);
        send_item(scb_pkg::OP_LOAD, 8'hFF, 16'h0001, 8'h00);
        send_item(scb_pkg::OP_READ, 8'h00, 16'h0000, 8'd0);    // load after build: invalid
        send_item(scb_pkg::OP_LOAD, 8'h12, 16'h0001, 8'h00);   // ties keep load order
        send_item(scb_pkg::OP_LOAD, 8'h34, 16'h8000, 8'h00);
        send_item(scb_pkg::OP_BUILD, 8'h00, 16'h0000, 8'h00);
        read_all(1);
        send_item(scb_pkg::OP_READ, 8'h00, 16'h0000, 8'hFF);
        send_item(scb_pkg::OP_CLEAR, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(scb_pkg::OP_READ, 8'h00, 16'h0000, 8'd0);
    endtask

    // Full table, then dropped loads
    task automatic test_full_table();
        drain_reads();                                    // sender waits for all results
        send_item(scb_pkg::OP_CLEAR, 8'h00, 16'h0000, 8'h00);
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            send_item(scb_pkg::OP_LOAD, 8'(i), 16'($urandom_range(1, 3)), 8'($urandom));
        send_item(scb_pkg::OP_BUILD, 8'h00, 16'h0000, 8'h00);
        for (int i = 0; i < 12; i++)
            send_item(scb_pkg::OP_READ, 8'h00, 16'h0000, 8'($urandom_range(0, 255)));
        send_item(scb_pkg::OP_READ, 8'h00, 16'h0000, 8'd255);
    endtask

    // Well-formed sessions with random content, plus some noise
    task automatic test_random_sessions();
        int n;
        while (items_sent < 740)
        begin
            send_item(scb_pkg::OP_CLEAR, 8'($urandom), 16'($urandom), 8'($urandom));
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 3))
                    0: send_item(scb_pkg::OP_LOAD, 8'($urandom), 16'($urandom_range(0, 3)),
                                 8'($urandom));
                    1: send_item(scb_pkg::OP_LOAD, 8'($urandom), 16'($urandom),
                                 8'($urandom));
                    default: send_item(scb_pkg::OP_LOAD, 8'($urandom),
                                       16'($urandom_range(1, 300)), 8'($urandom));
                endcase
            end
            if ($urandom_range(0, 9) != 0)
                send_item(scb_pkg::OP_BUILD, 8'($urandom), 16'($urandom), 8'($urandom));
            if ($urandom_range(0, 5) == 0)
                send_item(scb_pkg::OP_LOAD, 8'($urandom), 16'($urandom), 8'($urandom));
            read_all($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0)
                send_item(2'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    // Receiver stall pattern: quiet stretches and busy stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (($time / 4000) % 3 == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // Result checker
    always @(posedge clk)
    begin
        code_entry_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            reads_seen++;
            if (pending_reads.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h/%h", $time,
                         m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                e = pending_reads.pop_front();
                if (m_axis_tdata[7:0] !== e.sym || m_axis_tdata[12:8] !== e.len ||
                    m_axis_tdata[36:13] !== e.code || m_axis_tuser[0] !== e.valid)
                begin
                    $display("%0t: mismatch, expected sym %h len %0d code %h valid %b",
                             $time, e.sym, e.len, e.code, e.valid);
                    $display("%0t:           actual sym %h len %0d code %h valid %b",
                             $time, m_axis_tdata[7:0], m_axis_tdata[12:8],
                             m_axis_tdata[36:13], m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        reads_seen = 0;
        items_sent = 0;
        idle_cycles = 0;
        burst_left = 0;
        tbl_used = 0;
        tbl_total = 0;
        tbl_built = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = scb_pkg::OP_CLEAR;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random_sessions();
        drain_reads();
        $display("Covered %0d items and %0d read results, incl. full table, ties, empty",
                 items_sent, reads_seen);
        $display("builds and reads of stale or unbuilt tables.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
